@@ hw/rtl/rbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Relativistic Boris push: shared definitions
// Fixed-point widths, vector and payload types, and the rounding, squaring and
// saturation helpers of the pipeline, whose arithmetic units share the widths.
// ----------------------------------------------------------------------------
package rbp_pkg;

	localparam int FRAC_BITS = 16;

	// Configuration port: two 32-bit registers at byte addresses 0 and 4.
	localparam int ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_HALF_QM_DT = 1'b0,
		REG_TIME_STEP  = 1'b1
	} reg_idx_t;

	localparam logic [30:0] TS_RESET = 31'(1) << FRAC_BITS;

	// Square root radicand and root widths.
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;

	// Width of a sum of unity and three rounded squares.
	localparam int SUM_W = RAD_W - FRAC_BITS;

	// Inverse gamma never exceeds one, the rotation factor never exceeds two.
	localparam int IG_W = FRAC_BITS + 1;
	localparam int T_W  = FRAC_BITS + 2;

	localparam int IGN_W = ((2 * FRAC_BITS > ROOT_W) ? 2 * FRAC_BITS : ROOT_W) + 1;
	localparam int TN_W  = ((2 * FRAC_BITS + 2 > SUM_W) ? 2 * FRAC_BITS + 2 : SUM_W) + 1;

	localparam logic [SUM_W-1:0] ONE_S   = SUM_W'(1) << FRAC_BITS;
	localparam logic [IGN_W-1:0] IGN_ONE = IGN_W'(1) << (2 * FRAC_BITS);
	localparam logic [TN_W-1:0]  TN_ONE  = TN_W'(1) << (2 * FRAC_BITS + 1);
	localparam logic [IG_W-1:0]  IG_MAX  = IG_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0]   T_MAX   = T_W'(1) << (FRAC_BITS + 1);

	// Cyclic neighbours for the cross products.
	localparam int NEXT_IDX [3] = '{1, 2, 0};
	localparam int PREV_IDX [3] = '{2, 0, 1};

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0] vec_t;
	typedef logic signed [63:0] prod_t;
	typedef prod_t [2:0] pvec_t;

	typedef struct packed {
		vec_t pos;
		vec_t um;
		vec_t ep;
		vec_t bv;
	} carry_t;

	typedef struct packed {
		vec_t pos;
		vec_t un;
	} pass_t;

	localparam prod_t S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam prod_t S32_MIN = 64'shFFFF_FFFF_8000_0000;

	function automatic prod_t mul_ss(input word_t a, input word_t b);
		prod_t aa;
		prod_t bb;
		aa = a;
		bb = b;
		return aa * bb;
	endfunction

	// Round half up, then floor shift by the fraction width.
	function automatic prod_t rnd(input prod_t p);
		prod_t r;
		r = p + $signed(64'(1) << (FRAC_BITS - 1));
		return r >>> FRAC_BITS;
	endfunction

	function automatic word_t sat32(input prod_t v);
		word_t r;
		if (v > S32_MAX) begin
			r = S32_MAX[31:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic word_t lo32(input prod_t v);
		return v[31:0];
	endfunction

	// Rounded square of a non-negative product.
	function automatic logic [SUM_W-1:0] sq_rnd(input prod_t p);
		logic [63:0] r;
		r = $unsigned(p) + (64'(1) << (FRAC_BITS - 1));
		r = r >> FRAC_BITS;
		return r[SUM_W-1:0];
	endfunction

	function automatic word_t zext_w(input logic [T_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w;
	endfunction

endpackage

@@ hw/rtl/relativistic_boris_push_core.sv @@
// ----------------------------------------------------------------------------
// Relativistic Boris particle pusher
// Pipelined push of one particle per clock unless held: field scaling, half
// kicks, magnetic rotation about B/gamma and position advance in Q16.16.
// ----------------------------------------------------------------------------
// The core takes one particle beat per clock while in_ready is high and returns
// one saturated result beat for each, in order. The path from input to result
// runs through the two 32-stage square root pipes that form the Lorentz
// factors and the three dividers (17, 18 and 17 stages) that form the two
// inverse gammas and the rotation factor, and through multiply, round and add
// stages. Results leave through an output register backed by one skid entry:
// the pipeline keeps moving while a single result waits, and the whole
// pipeline, with in_ready, holds only when both entries are occupied.
// half_qm_dt and time_step are read live by the pipeline, so they should be
// written only while no particle is in flight. Both registers sit on an
// APB-style port, half_qm_dt at address 0 and time_step at address 4.
module relativistic_boris_push_core (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic signed [31:0]         pos_z,
	input  logic signed [31:0]         mom_x,
	input  logic signed [31:0]         mom_y,
	input  logic signed [31:0]         mom_z,
	input  logic signed [31:0]         efield_x,
	input  logic signed [31:0]         efield_y,
	input  logic signed [31:0]         efield_z,
	input  logic signed [31:0]         bfield_x,
	input  logic signed [31:0]         bfield_y,
	input  logic signed [31:0]         bfield_z,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         new_pos_x,
	output logic signed [31:0]         new_pos_y,
	output logic signed [31:0]         new_pos_z,
	output logic signed [31:0]         new_mom_x,
	output logic signed [31:0]         new_mom_y,
	output logic signed [31:0]         new_mom_z
);
	import rbp_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. Only the register select bit is decoded,
	// so the low address bits alias.
	// ------------------------------------------------------------------
	word_t       half_qm_dt_q;
	logic [30:0] time_step_q;
	logic        cfg_wr;
	reg_idx_t    cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_qm_dt_q <= '0;
			time_step_q  <= TS_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_HALF_QM_DT: half_qm_dt_q <= pwdata;
				REG_TIME_STEP:  time_step_q  <= pwdata[30:0];
				default:        half_qm_dt_q <= half_qm_dt_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_HALF_QM_DT: prdata = half_qm_dt_q;
			REG_TIME_STEP:  prdata = {1'b0, time_step_q};
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline advance. The whole pipeline moves together; it holds only
	// when the skid entry is occupied, which is a registered condition, so
	// there is no combinational path from out_ready to in_ready.
	// ------------------------------------------------------------------
	logic en;
	logic out_valid_q;
	logic skid_valid_q;
	pass_t out_res_q;
	pass_t skid_res_q;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	vec_t pos_in, mom_in, e_in, b_in;
	assign pos_in = {pos_z, pos_y, pos_x};
	assign mom_in = {mom_z, mom_y, mom_x};
	assign e_in   = {efield_z, efield_y, efield_x};
	assign b_in   = {bfield_z, bfield_y, bfield_x};

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20;
	logic v_s21, v_s22, v_s23, v_s24;
	logic g1_v, ig1_v, t_v, g2_v, ig2_v;

	// Field scaling and first half kick.
	pvec_t pe_s1, pb_s1;
	vec_t  pos_s1, mom_s1;
	vec_t  ep_s2, bp_s2, pos_s2, mom_s2;
	carry_t c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10, c_s11;
	carry_t c_s12, c_s13, c_s14, c_s15, c_s16;
	pvec_t sq_s4;
	logic [RAD_W-1:0] rad_s5;
	logic [SUM_W-1:0] s5_sum;

	// First inverse gamma.
	logic [ROOT_W-1:0] g1_root;
	logic [$bits(carry_t)-1:0] g1_pay;
	logic [IGN_W-1:0] n_s6;
	logic [ROOT_W-1:0] d_s6;
	logic [IG_W-1:0] ig1_q;
	logic [$bits(carry_t)-1:0] ig1_pay;
	carry_t ig1_car;

	// Rotation vector and factor.
	pvec_t pbb_s7, sqb_s9;
	logic [SUM_W-1:0] d_s10;
	logic [SUM_W-1:0] d_s11;
	logic [TN_W-1:0] n_s11;
	logic [T_W-1:0] t_q;
	logic [$bits(carry_t)-1:0] t_pay;
	carry_t t_car;

	// Rotation.
	pvec_t pa_s12, pb_s12, pst_s14, pu_s16, pv_s16;
	logic [T_W-1:0] t_s12, t_s13;
	vec_t sv_s13, up_s15;

	// Second half kick, second inverse gamma and position advance.
	pass_t p_s17, p_s18, p_s19, p_s20, p_s21, p_s22, p_s23, res_s24;
	pvec_t squ_s18, pvel_s21, pt_s23;
	logic [SUM_W-1:0] s19_sum;
	logic [RAD_W-1:0] rad_s19;
	logic [ROOT_W-1:0] g2_root;
	logic [$bits(pass_t)-1:0] g2_pay;
	logic [IGN_W-1:0] n_s20;
	logic [ROOT_W-1:0] d_s20;
	logic [IG_W-1:0] ig2_q;
	logic [$bits(pass_t)-1:0] ig2_pay;
	pass_t ig2_car;
	vec_t vel_s22;

	// Payloads leaving the dividers, seen as their structures so that the
	// first product of each section lines up with its own quotient.
	assign ig1_car = ig1_pay;
	assign t_car   = t_pay;
	assign ig2_car = ig2_pay;

	assign s5_sum  = ONE_S + sq_rnd(sq_s4[0]) + sq_rnd(sq_s4[1]) + sq_rnd(sq_s4[2]);
	assign s19_sum = ONE_S + sq_rnd(squ_s18[0]) + sq_rnd(squ_s18[1]) + sq_rnd(squ_s18[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0; v_s16 <= 1'b0;
			v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0; v_s20 <= 1'b0;
			v_s21 <= 1'b0; v_s22 <= 1'b0; v_s23 <= 1'b0; v_s24 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid; v_s2  <= v_s1;  v_s3  <= v_s2;  v_s4  <= v_s3;
			v_s5  <= v_s4;     v_s6  <= g1_v;  v_s7  <= ig1_v; v_s8  <= v_s7;
			v_s9  <= v_s8;     v_s10 <= v_s9;  v_s11 <= v_s10; v_s12 <= t_v;
			v_s13 <= v_s12;    v_s14 <= v_s13; v_s15 <= v_s14; v_s16 <= v_s15;
			v_s17 <= v_s16;    v_s18 <= v_s17; v_s19 <= v_s18; v_s20 <= g2_v;
			v_s21 <= ig2_v;    v_s22 <= v_s21; v_s23 <= v_s22; v_s24 <= v_s23;
		end
	end

	// Scale the fields, apply the first half kick and form the radicand for gamma.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pe_s1[i] <= mul_ss(half_qm_dt_q, e_in[i]);
				pb_s1[i] <= mul_ss(half_qm_dt_q, b_in[i]);
				ep_s2[i] <= sat32(rnd(pe_s1[i]));
				bp_s2[i] <= sat32(rnd(pb_s1[i]));
				c_s3.um[i] <= sat32(prod_t'(mom_s2[i]) + prod_t'(ep_s2[i]));
				sq_s4[i] <= mul_ss(c_s3.um[i], c_s3.um[i]);
			end
			pos_s1     <= pos_in;
			mom_s1     <= mom_in;
			pos_s2     <= pos_s1;
			mom_s2     <= mom_s1;
			c_s3.pos   <= pos_s2;
			c_s3.ep    <= ep_s2;
			c_s3.bv    <= bp_s2;
			c_s4       <= c_s3;
			rad_s5     <= {s5_sum, {FRAC_BITS{1'b0}}};
			c_s5       <= c_s4;
		end
	end

	rbp_isqrt #(
		.RAD_W (RAD_W),
		.PAY_W ($bits(carry_t))
	) u_gamma1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.rad       (rad_s5),
		.in_pay    (c_s5),
		.out_valid (g1_v),
		.root      (g1_root),
		.out_pay   (g1_pay)
	);

	// Rounded reciprocal of gamma: numerator gets half the divisor added.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s6 <= IGN_ONE + IGN_W'(g1_root >> 1);
			d_s6 <= g1_root;
			c_s6 <= g1_pay;
		end
	end

	rbp_div #(
		.NUM_W (IGN_W),
		.DEN_W (ROOT_W),
		.Q_W   (IG_W),
		.PAY_W ($bits(carry_t))
	) u_inv_gamma1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (n_s6),
		.den       (d_s6),
		.in_pay    (c_s6),
		.out_valid (ig1_v),
		.quo       (ig1_q),
		.out_pay   (ig1_pay)
	);

	// Rotation vector B'/gamma and the denominator 1 + |bb|^2.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s7     <= ig1_pay;
			c_s8.pos <= c_s7.pos;
			c_s8.um  <= c_s7.um;
			c_s8.ep  <= c_s7.ep;
			for (int i = 0; i < 3; i++) begin
				pbb_s7[i]  <= mul_ss(ig1_car.bv[i], zext_w(T_W'(ig1_q)));
				c_s8.bv[i] <= lo32(rnd(pbb_s7[i]));
				sqb_s9[i]  <= mul_ss(c_s8.bv[i], c_s8.bv[i]);
			end
			c_s9  <= c_s8;
			d_s10 <= ONE_S + sq_rnd(sqb_s9[0]) + sq_rnd(sqb_s9[1]) + sq_rnd(sqb_s9[2]);
			c_s10 <= c_s9;
			n_s11 <= TN_ONE + TN_W'(d_s10 >> 1);
			d_s11 <= d_s10;
			c_s11 <= c_s10;
		end
	end

	rbp_div #(
		.NUM_W (TN_W),
		.DEN_W (SUM_W),
		.Q_W   (T_W),
		.PAY_W ($bits(carry_t))
	) u_rot_factor (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.num       (n_s11),
		.den       (d_s11),
		.in_pay    (c_s11),
		.out_valid (t_v),
		.quo       (t_q),
		.out_pay   (t_pay)
	);

	// Boris rotation, then the second half kick and the radicand for the second gamma.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s12 <= t_pay;
			t_s12 <= t_q;
			c_s13 <= c_s12;
			t_s13 <= t_s12;
			c_s14 <= c_s13;
			c_s15 <= c_s14;
			c_s16 <= c_s15;
			for (int i = 0; i < 3; i++) begin
				pa_s12[i]  <= mul_ss(t_car.um[NEXT_IDX[i]], t_car.bv[PREV_IDX[i]]);
				pb_s12[i]  <= mul_ss(t_car.um[PREV_IDX[i]], t_car.bv[NEXT_IDX[i]]);
				sv_s13[i]  <= sat32(prod_t'(c_s12.um[i]) + rnd(pa_s12[i]) - rnd(pb_s12[i]));
				pst_s14[i] <= mul_ss(sv_s13[i], zext_w(t_s13));
				up_s15[i]  <= sat32(rnd(pst_s14[i]));
				pu_s16[i]  <= mul_ss(up_s15[NEXT_IDX[i]], c_s15.bv[PREV_IDX[i]]);
				pv_s16[i]  <= mul_ss(up_s15[PREV_IDX[i]], c_s15.bv[NEXT_IDX[i]]);
				p_s17.un[i] <= sat32(prod_t'(c_s16.um[i]) + prod_t'(c_s16.ep[i])
					+ rnd(pu_s16[i]) - rnd(pv_s16[i]));
				squ_s18[i] <= mul_ss(p_s17.un[i], p_s17.un[i]);
			end
			p_s17.pos <= c_s16.pos;
			p_s18     <= p_s17;
			rad_s19   <= {s19_sum, {FRAC_BITS{1'b0}}};
			p_s19     <= p_s18;
		end
	end

	rbp_isqrt #(
		.RAD_W (RAD_W),
		.PAY_W ($bits(pass_t))
	) u_gamma2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s19),
		.rad       (rad_s19),
		.in_pay    (p_s19),
		.out_valid (g2_v),
		.root      (g2_root),
		.out_pay   (g2_pay)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s20 <= IGN_ONE + IGN_W'(g2_root >> 1);
			d_s20 <= g2_root;
			p_s20 <= g2_pay;
		end
	end

	rbp_div #(
		.NUM_W (IGN_W),
		.DEN_W (ROOT_W),
		.Q_W   (IG_W),
		.PAY_W ($bits(pass_t))
	) u_inv_gamma2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s20),
		.num       (n_s20),
		.den       (d_s20),
		.in_pay    (p_s20),
		.out_valid (ig2_v),
		.quo       (ig2_q),
		.out_pay   (ig2_pay)
	);

	// Velocity u/gamma, then the position advance by time_step * velocity.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s21      <= ig2_pay;
			p_s22      <= p_s21;
			p_s23      <= p_s22;
			res_s24.un <= p_s23.un;
			for (int i = 0; i < 3; i++) begin
				pvel_s21[i] <= mul_ss(ig2_car.un[i], zext_w(T_W'(ig2_q)));
				vel_s22[i]  <= lo32(rnd(pvel_s21[i]));
				pt_s23[i]   <= mul_ss({1'b0, time_step_q}, vel_s22[i]);
				res_s24.pos[i] <= sat32(prod_t'(p_s23.pos[i]) + rnd(pt_s23[i]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register with one skid entry. A beat leaves the last stage
	// whenever the pipeline advances; it lands in the output register if
	// that is free or being drained, otherwise in the skid entry.
	// ------------------------------------------------------------------
	logic push;
	logic pop;

	assign push = en && v_s24;
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !pop) begin
			skid_valid_q <= push;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_res_q <= skid_res_q;
			end
		end else if (out_valid_q && !pop) begin
			if (push) begin
				skid_res_q <= res_s24;
			end
		end else if (push) begin
			out_res_q <= res_s24;
		end
	end

	assign out_valid = out_valid_q;
	assign new_pos_x = out_res_q.pos[0];
	assign new_pos_y = out_res_q.pos[1];
	assign new_pos_z = out_res_q.pos[2];
	assign new_mom_x = out_res_q.un[0];
	assign new_mom_y = out_res_q.un[1];
	assign new_mom_z = out_res_q.un[2];

	// ------------------------------------------------------------------
	// Checks on the output buffering and on the ranges of the quotients.
	// ------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry occupied while the output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ready) |=> (skid_valid_q && $stable(skid_res_q)))
		else $error("skid entry lost or changed while the output was blocked");

	a_inv_gamma_range: assert property (@(posedge clk) disable iff (!arst_n)
		ig1_v |-> (ig1_q <= IG_MAX))
		else $error("inverse gamma above one");

	a_rot_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		t_v |-> (t_q <= T_MAX))
		else $error("rotation factor above two");

endmodule

@@ hw/rtl/rbp_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit resolved per register stage, with a side
// payload that travels alongside so that the caller needs no delay line.
// ----------------------------------------------------------------------------
module rbp_isqrt #(
	parameter int RAD_W = rbp_pkg::RAD_W,
	parameter int PAY_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [RAD_W-1:0]   rad,
	input  logic [PAY_W-1:0]   in_pay,
	output logic               out_valid,
	output logic [RAD_W/2-1:0] root,
	output logic [PAY_W-1:0]   out_pay
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	logic             v_s    [1:ROOT_W];
	logic [REM_W-1:0] rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [RAD_W-1:0] rad_s  [1:ROOT_W];
	logic [PAY_W-1:0] pay_s  [1:ROOT_W];

	genvar k;
	for (k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vi;
		logic [REM_W-1:0]  remi;
		logic [ROOT_W-1:0] rooti;
		logic [RAD_W-1:0]  radi;
		logic [PAY_W-1:0]  payi;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  cand;
		logic              ge;

		if (k == 0) begin : g_first
			assign vi    = in_valid;
			assign remi  = '0;
			assign rooti = '0;
			assign radi  = rad;
			assign payi  = in_pay;
		end else begin : g_next
			assign vi    = v_s[k];
			assign remi  = rem_s[k];
			assign rooti = root_s[k];
			assign radi  = rad_s[k];
			assign payi  = pay_s[k];
		end

		assign rem_sh = {remi[REM_W-3:0], radi[RAD_W-1:RAD_W-2]};
		assign cand   = REM_W'({rooti, 2'b01});
		assign ge     = rem_sh >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_sh - cand : rem_sh;
				root_s[k+1] <= {rooti[ROOT_W-2:0], ge};
				rad_s[k+1]  <= radi << 2;
				pay_s[k+1]  <= payi;
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_pay   = pay_s[ROOT_W];

endmodule

@@ hw/rtl/rbp_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, most significant
// first. The quotient must fit in Q_W bits. A side payload travels alongside.
// ----------------------------------------------------------------------------
module rbp_div #(
	parameter int NUM_W = rbp_pkg::IGN_W,
	parameter int DEN_W = rbp_pkg::ROOT_W,
	parameter int Q_W   = rbp_pkg::IG_W,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [PAY_W-1:0] out_pay
);
	localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic             v_s   [1:Q_W];
	logic [NUM_W-1:0] rem_s [1:Q_W];
	logic [DEN_W-1:0] den_s [1:Q_W];
	logic [Q_W-1:0]   q_s   [1:Q_W];
	logic [PAY_W-1:0] pay_s [1:Q_W];

	genvar k;
	for (k = 0; k < Q_W; k++) begin : g_stage
		logic             vi;
		logic [NUM_W-1:0] remi;
		logic [DEN_W-1:0] deni;
		logic [Q_W-1:0]   qi;
		logic [PAY_W-1:0] payi;
		logic [CMP_W-1:0] dsh;
		logic [CMP_W-1:0] rext;
		logic [CMP_W-1:0] diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign vi   = in_valid;
			assign remi = num;
			assign deni = den;
			assign qi   = '0;
			assign payi = in_pay;
		end else begin : g_next
			assign vi   = v_s[k];
			assign remi = rem_s[k];
			assign deni = den_s[k];
			assign qi   = q_s[k];
			assign payi = pay_s[k];
		end

		assign dsh  = CMP_W'(deni) << (Q_W - 1 - k);
		assign rext = CMP_W'(remi);
		assign ge   = rext >= dsh;
		assign diff = rext - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[NUM_W-1:0] : remi;
				den_s[k+1] <= deni;
				q_s[k+1]   <= {qi[Q_W-2:0], ge};
				pay_s[k+1] <= payi;
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign quo       = q_s[Q_W];
	assign out_pay   = pay_s[Q_W];

endmodule
